// ----- src/mhpq_pkg.sv -----
// Shared types, constants and helper functions for the min-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 2;
    localparam int KEY_W    = 32;
    localparam int ENTRY_W  = KEY_W + 1;
    localparam int FILL_W   = 7;
    localparam int STAT_W   = 2;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    typedef logic [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
        logic                    kind;
    } in_word_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic                    out_kind;
        logic [STAT_W-1:0]       status;
        logic [FILL_W-1:0]       fill;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_UP_PUT,
        S_EX_ROOT,
        S_EX_LAST,
        S_EX_LOAD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [2:0] {
        RD_ROOT,
        RD_LAST,
        RD_PARENT,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_MOV,
        WR_PARENT,
        WR_CHILD
    } wr_src_t;

    typedef enum logic [2:0] {
        POS_HOLD,
        POS_CNT,
        POS_ZERO,
        POS_PARENT,
        POS_CHILD
    } pos_op_t;

    typedef enum logic [1:0] {
        MOV_HOLD,
        MOV_INPUT,
        MOV_RDATA
    } mov_op_t;

    typedef struct packed {
        cnt_op_t           cnt_op;
        rd_sel_t           rd_sel;
        logic              wr_en;
        wr_src_t           wr_src;
        pos_op_t           pos_op;
        mov_op_t           mov_op;
        logic              lch_load;
        logic              root_load;
        logic              status_load;
        logic [STAT_W-1:0] status_val;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic parent_zero;
        logic up_lt;
        logic has_left;
        logic dn_lt;
    } dp_stat_t;

    function automatic entry_t encode_entry(logic signed [KEY_W-1:0] key, logic kind);
        return {~key[KEY_W-1], key[KEY_W-2:0], kind};
    endfunction

    function automatic logic signed [KEY_W-1:0] entry_key(entry_t e);
        return {~e[ENTRY_W-1], e[ENTRY_W-2:1]};
    endfunction

endpackage

// ----- src/mhpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/mhpq_datapath.sv -----
// Heap datapath: entry store, hole position, moving entry, count and result word.
`timescale 1ns / 1ps

module mhpq_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  mhpq_pkg::in_word_t  item,
    input  mhpq_pkg::dp_cmd_t   cmd,
    output mhpq_pkg::dp_stat_t  stat,
    output mhpq_pkg::out_word_t result
);

    logic [mhpq_pkg::ADDR_W-1:0]       pos_reg, pos_next;
    logic [mhpq_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    mhpq_pkg::entry_t                  mov_reg, mov_next;
    mhpq_pkg::entry_t                  lch_reg;
    logic signed [mhpq_pkg::KEY_W-1:0] res_key_reg;
    logic                              res_kind_reg;
    logic [mhpq_pkg::STAT_W-1:0]       status_reg;

    logic [mhpq_pkg::ADDR_W-1:0] parent_idx;
    logic [mhpq_pkg::IDX_W-1:0]  l_idx;
    logic [mhpq_pkg::IDX_W-1:0]  r_idx;
    logic [mhpq_pkg::IDX_W-1:0]  cnt_ext;
    logic                        has_right;
    logic                        use_right;
    mhpq_pkg::entry_t            child;
    logic [mhpq_pkg::ADDR_W-1:0] child_idx;
    logic [mhpq_pkg::ADDR_W-1:0] rd_addr;
    mhpq_pkg::entry_t            rd_data;
    mhpq_pkg::entry_t            wr_data;

    assign parent_idx = (pos_reg - mhpq_pkg::ADDR_W'(1)) >> 1;
    assign l_idx      = mhpq_pkg::IDX_W'({pos_reg, 1'b1});
    assign r_idx      = l_idx + mhpq_pkg::IDX_W'(1);
    assign cnt_ext    = mhpq_pkg::IDX_W'(cnt_reg);
    assign has_right  = r_idx < cnt_ext;
    assign use_right  = has_right && (rd_data < lch_reg);
    assign child      = use_right ? rd_data : lch_reg;
    assign child_idx  = use_right ? r_idx[mhpq_pkg::ADDR_W-1:0] : l_idx[mhpq_pkg::ADDR_W-1:0];

    assign stat.empty       = cnt_reg == '0;
    assign stat.full        = cnt_reg == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY);
    assign stat.parent_zero = parent_idx == '0;
    assign stat.up_lt       = mov_reg < rd_data;
    assign stat.has_left    = l_idx < cnt_ext;
    assign stat.dn_lt       = child < mov_reg;

    always_comb
    begin
        unique case (cmd.rd_sel)
            mhpq_pkg::RD_ROOT:   rd_addr = '0;
            mhpq_pkg::RD_LAST:   rd_addr = cnt_reg[mhpq_pkg::ADDR_W-1:0];
            mhpq_pkg::RD_PARENT: rd_addr = parent_idx;
            mhpq_pkg::RD_LEFT:   rd_addr = l_idx[mhpq_pkg::ADDR_W-1:0];
            mhpq_pkg::RD_RIGHT:  rd_addr = r_idx[mhpq_pkg::ADDR_W-1:0];
            default:             rd_addr = '0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_src)
            mhpq_pkg::WR_MOV:    wr_data = mov_reg;
            mhpq_pkg::WR_PARENT: wr_data = rd_data;
            mhpq_pkg::WR_CHILD:  wr_data = child;
            default:             wr_data = mov_reg;
        endcase
    end

    mhpq_ram #(
        .WIDTH (mhpq_pkg::ENTRY_W),
        .DEPTH (mhpq_pkg::CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (pos_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        unique case (cmd.cnt_op)
            mhpq_pkg::CNT_HOLD: cnt_next = cnt_reg;
            mhpq_pkg::CNT_INC:  cnt_next = cnt_reg + mhpq_pkg::CNT_W'(1);
            mhpq_pkg::CNT_DEC:  cnt_next = cnt_reg - mhpq_pkg::CNT_W'(1);
            default:            cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.pos_op)
            mhpq_pkg::POS_HOLD:   pos_next = pos_reg;
            mhpq_pkg::POS_CNT:    pos_next = cnt_reg[mhpq_pkg::ADDR_W-1:0];
            mhpq_pkg::POS_ZERO:   pos_next = '0;
            mhpq_pkg::POS_PARENT: pos_next = parent_idx;
            mhpq_pkg::POS_CHILD:  pos_next = child_idx;
            default:              pos_next = pos_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.mov_op)
            mhpq_pkg::MOV_HOLD:  mov_next = mov_reg;
            mhpq_pkg::MOV_INPUT: mov_next = mhpq_pkg::encode_entry(item.key, item.kind);
            mhpq_pkg::MOV_RDATA: mov_next = rd_data;
            default:             mov_next = mov_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        mov_reg <= mov_next;
        if (cmd.lch_load)
        begin
            lch_reg <= rd_data;
        end
        if (cmd.status_load)
        begin
            status_reg   <= cmd.status_val;
            res_key_reg  <= '0;
            res_kind_reg <= 1'b0;
        end
        else if (cmd.root_load)
        begin
            res_key_reg  <= mhpq_pkg::entry_key(rd_data);
            res_kind_reg <= rd_data[0];
        end
    end

    assign result.out_key  = res_key_reg;
    assign result.out_kind = res_kind_reg;
    assign result.status   = status_reg;
    assign result.fill     = mhpq_pkg::FILL_W'(cnt_reg);

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_wr_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (mhpq_pkg::CNT_W'(pos_reg) < cnt_reg))
        else $error("store write outside held entries");

endmodule

// ----- src/mhpq_ctrl.sv -----
// Heap controller: sequences insert sift-up and extract sift-down over the datapath.
`timescale 1ns / 1ps

module mhpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               item_cmd,
    input  mhpq_pkg::dp_stat_t stat,
    output mhpq_pkg::dp_cmd_t  cmd,
    output logic               busy,
    output logic               done
);

    mhpq_pkg::state_t state_reg, state_next;
    logic             accept;

    assign accept = start && (state_reg == mhpq_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhpq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mhpq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (item_cmd == mhpq_pkg::CMD_EXTRACT)
                    begin
                        state_next = stat.empty ? mhpq_pkg::S_DONE : mhpq_pkg::S_EX_ROOT;
                    end
                    else if (stat.full)
                    begin
                        state_next = mhpq_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = stat.empty ? mhpq_pkg::S_UP_PUT : mhpq_pkg::S_UP_RD;
                    end
                end
            end
            mhpq_pkg::S_UP_RD:   state_next = mhpq_pkg::S_UP_CMP;
            mhpq_pkg::S_UP_CMP:
            begin
                if (!stat.up_lt)
                begin
                    state_next = mhpq_pkg::S_DONE;
                end
                else
                begin
                    state_next = stat.parent_zero ? mhpq_pkg::S_UP_PUT : mhpq_pkg::S_UP_RD;
                end
            end
            mhpq_pkg::S_UP_PUT:  state_next = mhpq_pkg::S_DONE;
            mhpq_pkg::S_EX_ROOT: state_next = mhpq_pkg::S_EX_LAST;
            mhpq_pkg::S_EX_LAST:
            begin
                state_next = stat.empty ? mhpq_pkg::S_DONE : mhpq_pkg::S_EX_LOAD;
            end
            mhpq_pkg::S_EX_LOAD: state_next = mhpq_pkg::S_DN_RDL;
            mhpq_pkg::S_DN_RDL:
            begin
                state_next = stat.has_left ? mhpq_pkg::S_DN_RDR : mhpq_pkg::S_DONE;
            end
            mhpq_pkg::S_DN_RDR:  state_next = mhpq_pkg::S_DN_CMP;
            mhpq_pkg::S_DN_CMP:
            begin
                state_next = stat.dn_lt ? mhpq_pkg::S_DN_RDL : mhpq_pkg::S_DONE;
            end
            mhpq_pkg::S_DONE:    state_next = mhpq_pkg::S_IDLE;
            default:             state_next = mhpq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.cnt_op      = mhpq_pkg::CNT_HOLD;
        cmd.rd_sel      = mhpq_pkg::RD_ROOT;
        cmd.wr_en       = 1'b0;
        cmd.wr_src      = mhpq_pkg::WR_MOV;
        cmd.pos_op      = mhpq_pkg::POS_HOLD;
        cmd.mov_op      = mhpq_pkg::MOV_HOLD;
        cmd.lch_load    = 1'b0;
        cmd.root_load   = 1'b0;
        cmd.status_load = 1'b0;
        cmd.status_val  = mhpq_pkg::STATUS_OK;
        unique case (state_reg)
            mhpq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.status_load = 1'b1;
                    if (item_cmd == mhpq_pkg::CMD_EXTRACT)
                    begin
                        if (stat.empty)
                        begin
                            cmd.status_val = mhpq_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            cmd.cnt_op = mhpq_pkg::CNT_DEC;
                        end
                    end
                    else if (stat.full)
                    begin
                        cmd.status_val = mhpq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        cmd.cnt_op = mhpq_pkg::CNT_INC;
                        cmd.pos_op = mhpq_pkg::POS_CNT;
                        cmd.mov_op = mhpq_pkg::MOV_INPUT;
                    end
                end
            end
            mhpq_pkg::S_UP_RD:
            begin
                cmd.rd_sel = mhpq_pkg::RD_PARENT;
            end
            mhpq_pkg::S_UP_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (stat.up_lt)
                begin
                    cmd.wr_src = mhpq_pkg::WR_PARENT;
                    cmd.pos_op = mhpq_pkg::POS_PARENT;
                end
            end
            mhpq_pkg::S_UP_PUT:
            begin
                cmd.wr_en = 1'b1;
            end
            mhpq_pkg::S_EX_ROOT:
            begin
                cmd.rd_sel = mhpq_pkg::RD_ROOT;
            end
            mhpq_pkg::S_EX_LAST:
            begin
                cmd.root_load = 1'b1;
                cmd.rd_sel    = mhpq_pkg::RD_LAST;
            end
            mhpq_pkg::S_EX_LOAD:
            begin
                cmd.mov_op = mhpq_pkg::MOV_RDATA;
                cmd.pos_op = mhpq_pkg::POS_ZERO;
            end
            mhpq_pkg::S_DN_RDL:
            begin
                cmd.rd_sel = mhpq_pkg::RD_LEFT;
                cmd.wr_en  = !stat.has_left;
            end
            mhpq_pkg::S_DN_RDR:
            begin
                cmd.lch_load = 1'b1;
                cmd.rd_sel   = mhpq_pkg::RD_RIGHT;
            end
            mhpq_pkg::S_DN_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (stat.dn_lt)
                begin
                    cmd.wr_src = mhpq_pkg::WR_CHILD;
                    cmd.pos_op = mhpq_pkg::POS_CHILD;
                end
            end
            mhpq_pkg::S_DONE:
            begin
                cmd.rd_sel = mhpq_pkg::RD_ROOT;
            end
            default:
            begin
                cmd.rd_sel = mhpq_pkg::RD_ROOT;
            end
        endcase
    end

    assign busy = state_reg != mhpq_pkg::S_IDLE;
    assign done = state_reg == mhpq_pkg::S_DONE;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted word did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    a_wr_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (cmd.mov_op == mhpq_pkg::MOV_HOLD && !cmd.status_load))
        else $error("store write while loading a new word");

endmodule

// ----- src/min_heap_priority_queue.sv -----
// Top level of the binary min-heap priority queue: controller plus datapath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------
//  command  | start in, busy out      | item   (cmd, key, kind)
//  result   | done out, one cycle     | result (out_key, out_kind, status, fill)
//
//  A word is taken when start is high and busy is low; busy stays high through done.
//  Insert: into an empty heap the entry is written at the root; else it climbs one
//  level per compare until its parent is not larger or it reaches the root.
//  Extract: an empty heap returns STATUS_EMPTY; else the root is returned, the last entry
//  moves to the root and descends a level per compare until it has no smaller child.
//  Reset empties the heap at once; the result strobe cannot be stalled.
`timescale 1ns / 1ps

module min_heap_priority_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mhpq_pkg::in_word_t  item,
    output logic                done,
    output mhpq_pkg::out_word_t result
);

    mhpq_pkg::dp_cmd_t  dp_cmd;
    mhpq_pkg::dp_stat_t dp_stat;

    mhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item_cmd (item.cmd),
        .stat     (dp_stat),
        .cmd      (dp_cmd),
        .busy     (busy),
        .done     (done)
    );

    mhpq_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (dp_cmd),
        .stat   (dp_stat),
        .result (result)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the min-heap priority queue: directed and random insert/extract traffic.
`timescale 1ns / 1ps

module testbench;

    localparam int TOTAL_WORDS = 1450;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic signed [mhpq_pkg::KEY_W-1:0] key;
        logic                              kind;
    } heap_slot_t;

    typedef struct {
        mhpq_pkg::in_word_t word;
        int                 idle_pct;
        bit                 drain;
    } command_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    mhpq_pkg::in_word_t  item = '0;
    logic                busy;
    logic                done;
    mhpq_pkg::out_word_t result;

    command_t            queued_commands[$];
    mhpq_pkg::out_word_t due_results[$];

    heap_slot_t heap_slots[mhpq_pkg::CAPACITY];
    int         heap_size = 0;

    int gen_fill = 0;
    int gen_total = 0;
    int gen_idle = 27;
    bit gen_drain = 1'b0;

    int mismatches = 0;
    int results_checked = 0;
    int n_insert = 0;
    int n_full = 0;
    int n_extract = 0;
    int n_empty = 0;
    int peak_fill = 0;
    int cycle_count = 0;

    min_heap_priority_queue DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit ranks_ahead(heap_slot_t a, heap_slot_t b);
        logic signed [mhpq_pkg::KEY_W-1:0] ka;
        logic signed [mhpq_pkg::KEY_W-1:0] kb;
        ka = a.key;
        kb = b.key;
        return (ka < kb) || (ka == kb && a.kind < b.kind);
    endfunction

    task automatic run_heap_op(input mhpq_pkg::in_word_t w, output mhpq_pkg::out_word_t r);
        heap_slot_t tmp;
        int         pos;
        int         up;
        int         best;
        int         l;
        r = '0;
        if (w.cmd == mhpq_pkg::CMD_INSERT)
        begin
            n_insert++;
            if (heap_size >= mhpq_pkg::CAPACITY)
            begin
                r.status = mhpq_pkg::STATUS_FULL;
                n_full++;
            end
            else
            begin
                pos = heap_size;
                heap_slots[pos] = '{key: w.key, kind: w.kind};
                heap_size++;
                while (pos > 0)
                begin
                    up = (pos - 1) / 2;
                    if (!ranks_ahead(heap_slots[pos], heap_slots[up]))
                        break;
                    tmp = heap_slots[pos];
                    heap_slots[pos] = heap_slots[up];
                    heap_slots[up] = tmp;
                    pos = up;
                end
            end
        end
        else
        begin
            n_extract++;
            if (heap_size == 0)
            begin
                r.status = mhpq_pkg::STATUS_EMPTY;
                n_empty++;
            end
            else
            begin
                r.out_key = heap_slots[0].key;
                r.out_kind = heap_slots[0].kind;
                heap_size--;
                if (heap_size > 0)
                begin
                    heap_slots[0] = heap_slots[heap_size];
                    pos = 0;
                    forever
                    begin
                        l = 2 * pos + 1;
                        best = pos;
                        if (l < heap_size && ranks_ahead(heap_slots[l], heap_slots[best]))
                            best = l;
                        if (l + 1 < heap_size && ranks_ahead(heap_slots[l + 1], heap_slots[best]))
                            best = l + 1;
                        if (best == pos)
                            break;
                        tmp = heap_slots[pos];
                        heap_slots[pos] = heap_slots[best];
                        heap_slots[best] = tmp;
                        pos = best;
                    end
                end
            end
        end
        if (heap_size > peak_fill)
            peak_fill = heap_size;
        r.fill = heap_size[mhpq_pkg::FILL_W-1:0];
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH %s", msg);
    endtask

    function automatic logic signed [mhpq_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom;
            3, 4:    return $signed($urandom_range(0, 12)) - 6;
            5:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh0000_0000;
                    3: return -32'sd1;
                    4: return 32'sh8000_0001;
                    default: return 32'sh7FFF_FFFE;
                endcase
            end
            6:       return 32'sh7FFF_FFFF - $urandom_range(0, 3);
            default: return 32'sh8000_0000 + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic queue_command(input logic cmd, input logic signed [mhpq_pkg::KEY_W-1:0] key,
                                 input logic kind);
        command_t c;
        c.word.cmd = cmd;
        c.word.key = key;
        c.word.kind = kind;
        c.idle_pct = gen_idle;
        c.drain = gen_drain || ($urandom_range(0, 99) < 2);
        gen_drain = 1'b0;
        queued_commands.push_back(c);
        gen_total++;
        if (cmd == mhpq_pkg::CMD_INSERT && gen_fill < mhpq_pkg::CAPACITY)
            gen_fill++;
        else if (cmd == mhpq_pkg::CMD_EXTRACT && gen_fill > 0)
            gen_fill--;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_words
        bit took;
        bit go;
        mhpq_pkg::out_word_t predicted;
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                run_heap_op(item, predicted);
                due_results.push_back(predicted);
                void'(queued_commands.pop_front());
            end
            if (!start || took)
            begin
                go = queued_commands.size() != 0;
                if (go && queued_commands[0].drain && due_results.size() != 0)
                    go = 1'b0;
                if (go && queued_commands[0].idle_pct != 0)
                begin
                    if (busy && !took)
                        go = $urandom_range(0, 7) == 0;
                    else
                        go = $urandom_range(0, 99) >= queued_commands[0].idle_pct;
                end
                start <= go;
                if (go)
                    item <= queued_commands[0].word;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        mhpq_pkg::out_word_t want;
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result word: %h", result));
            end
            else
            begin
                want = due_results.pop_front();
                if (result.out_key !== want.out_key)
                    note_mismatch($sformatf("result %0d out_key: got %h want %h",
                                            results_checked, result.out_key, want.out_key));
                if (result.out_kind !== want.out_kind)
                    note_mismatch($sformatf("result %0d out_kind: got %h want %h",
                                            results_checked, result.out_kind, want.out_kind));
                if (result.status !== want.status)
                    note_mismatch($sformatf("result %0d status: got %h want %h",
                                            results_checked, result.status, want.status));
                if (result.fill !== want.fill)
                    note_mismatch($sformatf("result %0d fill: got %h want %h",
                                            results_checked, result.fill, want.fill));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int seq_kind;
        int run_len;
        int extra;
        int want_pct;
        int ins_pct;
        int waited;
        bit first_seq;

        // directed: empty extract, key extremes, tie ordering, duplicates
        queue_command(mhpq_pkg::CMD_EXTRACT, 32'sh7FFF_FFFF, 1'b1);
        queue_command(mhpq_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 1'b1);
        queue_command(mhpq_pkg::CMD_INSERT, 32'sh8000_0000, 1'b0);
        queue_command(mhpq_pkg::CMD_INSERT, 32'sh0000_0000, 1'b1);
        queue_command(mhpq_pkg::CMD_INSERT, 32'sh0000_0000, 1'b0);
        queue_command(mhpq_pkg::CMD_INSERT, -32'sd1, 1'b1);
        queue_command(mhpq_pkg::CMD_INSERT, 32'sd1, 1'b0);
        queue_command(mhpq_pkg::CMD_INSERT, 32'sh8000_0000, 1'b1);
        queue_command(mhpq_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 1'b0);
        queue_command(mhpq_pkg::CMD_INSERT, 32'sd5, 1'b1);
        queue_command(mhpq_pkg::CMD_INSERT, 32'sd5, 1'b1);
        repeat (10)
            queue_command(mhpq_pkg::CMD_EXTRACT, pick_key(), 1'($urandom_range(0, 1)));
        queue_command(mhpq_pkg::CMD_EXTRACT, 32'sh0000_0000, 1'b0);
        queue_command(mhpq_pkg::CMD_EXTRACT, -32'sd1, 1'b1);

        first_seq = 1'b1;
        while (gen_total < TOTAL_WORDS)
        begin
            want_pct = (gen_total < TOTAL_WORDS / 3) ? 27 :
                       (gen_total < 2 * TOTAL_WORDS / 3) ? 49 : 0;
            if (want_pct != gen_idle)
            begin
                gen_idle = want_pct;
                gen_drain = 1'b1;
            end
            seq_kind = first_seq ? 0 : $urandom_range(0, 9);
            first_seq = 1'b0;
            if (seq_kind == 0)
            begin
                // fill to capacity, overflow, then drain (past empty when the drain reaches it)
                while (gen_fill < mhpq_pkg::CAPACITY)
                    queue_command(mhpq_pkg::CMD_INSERT, pick_key(), 1'($urandom_range(0, 1)));
                extra = $urandom_range(1, 3);
                repeat (extra)
                    queue_command(mhpq_pkg::CMD_INSERT, pick_key(), 1'($urandom_range(0, 1)));
                run_len = $urandom_range(0, 1) ? mhpq_pkg::CAPACITY :
                          $urandom_range(10, mhpq_pkg::CAPACITY);
                repeat (run_len)
                    queue_command(mhpq_pkg::CMD_EXTRACT, pick_key(), 1'($urandom_range(0, 1)));
                if (gen_fill == 0)
                    repeat ($urandom_range(1, 2))
                        queue_command(mhpq_pkg::CMD_EXTRACT, pick_key(),
                                      1'($urandom_range(0, 1)));
            end
            else if (seq_kind == 1)
            begin
                repeat (8)
                    queue_command(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
            end
            else
            begin
                run_len = $urandom_range(10, 30);
                repeat (run_len)
                begin
                    ins_pct = (gen_fill < 8) ? 75 :
                              (gen_fill > mhpq_pkg::CAPACITY - 8) ? 25 : 55;
                    if ($urandom_range(0, 99) < ins_pct)
                        queue_command(mhpq_pkg::CMD_INSERT, pick_key(),
                                      1'($urandom_range(0, 1)));
                    else
                        queue_command(mhpq_pkg::CMD_EXTRACT, pick_key(),
                                      1'($urandom_range(0, 1)));
                end
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (queued_commands.size() != 0 || start)
            @(negedge clk);
        waited = 0;
        while (due_results.size() != 0 && waited < 200)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (due_results.size() != 0)
        begin
            note_mismatch($sformatf("%0d expected results never arrived", due_results.size()));
        end

        $display("covered %0d inserts (%0d dropped when full), %0d extracts (%0d on empty)",
                 n_insert, n_full, n_extract, n_empty);
        $display("checked %0d results over three sender pacings, peak fill %0d",
                 results_checked, peak_fill);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
